>>> design/cpr_pkg.sv
package cpr_pkg;

	localparam int MAX_RUN_DEF     = 64;
	localparam int OFFSET_BITS_DEF = 32;
	localparam int QUEUE_DEPTH     = 4;
	localparam int OUT_DEPTH       = 2;

	localparam logic KIND_RUN     = 1'b0;
	localparam logic KIND_SUMMARY = 1'b1;

	localparam logic [7:0] OP_JMP_REL  = 8'hE9;
	localparam logic [7:0] OP_CALL_REL = 8'hE8;
	localparam logic [7:0] OP_JMP_SHRT = 8'hEB;
	localparam logic [7:0] OP_RET      = 8'hC3;
	localparam logic [7:0] OP_RET_IMM  = 8'hC2;
	localparam logic [7:0] OP_INT3     = 8'hCC;
	localparam logic [7:0] OP_NOP      = 8'h90;
	localparam logic [7:0] OP_GRP5     = 8'hFF;
	localparam logic [7:0] OP_JCC_LO   = 8'h70;
	localparam logic [7:0] OP_JCC_HI   = 8'h7F;
	localparam logic [7:0] OP_ESCAPE   = 8'h0F;
	localparam logic [7:0] OP_JCC2_LO  = 8'h80;
	localparam logic [7:0] OP_JCC2_HI  = 8'h8F;

	typedef struct packed {
		logic [7:0] live_byte;
		logic [7:0] stored_byte;
		logic       is_last;
	} in_beat_t;

	typedef struct packed {
		logic        kind;
		logic [31:0] run_offset;
		logic [6:0]  run_length;
		logic [31:0] run_count;
		logic        end_of_burst;
	} out_beat_t;

	typedef struct packed {
		logic        mismatch;
		logic        opcode;
		logic        escape;
		logic        cond_tail;
		logic        last;
		logic [31:0] offset;
	} cls_rec_t;

	function automatic logic is_patch_op(input logic [7:0] b);
		return b == OP_JMP_REL || b == OP_CALL_REL || b == OP_JMP_SHRT ||
			b == OP_RET || b == OP_RET_IMM || b == OP_INT3 || b == OP_NOP ||
			b == OP_GRP5 || (b >= OP_JCC_LO && b <= OP_JCC_HI);
	endfunction

endpackage

>>> design/cpr_front.sv
module cpr_front #(
	parameter int OFFSET_BITS = cpr_pkg::OFFSET_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              key_we,
	input  logic [63:0]       key_data,
	input  logic              in_valid,
	output logic              in_stall,
	input  cpr_pkg::in_beat_t in_data,
	output logic              push,
	output cpr_pkg::cls_rec_t push_rec,
	input  logic              q_full
);

	logic [63:0]            key_q;
	logic [OFFSET_BITS-1:0] off_q;
	logic [7:0]             key_byte;
	logic [7:0]             clean;
	logic [63:0]            off_wide;

	assign in_stall = q_full;
	assign push     = in_valid && !q_full;
	assign key_byte = key_q[{off_q[2:0], 3'b000} +: 8];
	assign clean    = in_data.stored_byte ^ key_byte;
	assign off_wide = 64'(off_q);

	always_comb begin
		push_rec.mismatch  = in_data.live_byte != clean;
		push_rec.opcode    = cpr_pkg::is_patch_op(in_data.live_byte);
		push_rec.escape    = in_data.live_byte == cpr_pkg::OP_ESCAPE;
		push_rec.cond_tail = in_data.live_byte >= cpr_pkg::OP_JCC2_LO &&
			in_data.live_byte <= cpr_pkg::OP_JCC2_HI;
		push_rec.last      = in_data.is_last;
		push_rec.offset    = off_wide[31:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q <= '0;
			off_q <= '0;
		end else begin
			if (key_we) begin
				key_q <= key_data;
			end
			if (push) begin
				if (in_data.is_last) begin
					off_q <= '0;
				end else if (off_q != '1) begin
					off_q <= off_q + 1'b1;
				end
			end
		end
	end

endmodule

>>> design/cpr_queue.sv
module cpr_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  cpr_pkg::cls_rec_t push_rec,
	output logic              full,
	input  logic              pop,
	output logic              empty,
	output cpr_pkg::cls_rec_t head
);

	localparam int DEPTH = cpr_pkg::QUEUE_DEPTH;
	localparam int PW    = $clog2(DEPTH);
	localparam int CW    = $clog2(DEPTH + 1);

	cpr_pkg::cls_rec_t entry_q [DEPTH];
	logic [PW-1:0]     wr_q;
	logic [PW-1:0]     rd_q;
	logic [CW-1:0]     cnt_q;

	assign full  = cnt_q == CW'(DEPTH);
	assign empty = cnt_q == '0;
	assign head  = entry_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_q] <= push_rec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

>>> design/cpr_back.sv
module cpr_back #(
	parameter int MAX_RUN = cpr_pkg::MAX_RUN_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               q_empty,
	input  cpr_pkg::cls_rec_t  rec,
	output logic               pop,
	output logic               out_valid,
	input  logic               out_stall,
	output cpr_pkg::out_beat_t out_data
);

	localparam int RW = $clog2(MAX_RUN + 1);

	logic              run_open_q;
	logic [31:0]       run_start_q;
	logic [RW-1:0]     run_bytes_q;
	logic              run_pl_q;
	logic              esc_q;
	logic [31:0]       found_q;

	cpr_pkg::out_beat_t obuf_q [cpr_pkg::OUT_DEPTH];
	cpr_pkg::out_beat_t obuf_nx [cpr_pkg::OUT_DEPTH];
	logic [1:0]         ocnt_q;
	logic [1:0]         ocnt_nx;

	logic               fresh;
	logic               cur_open;
	logic [31:0]        cur_start;
	logic [RW-1:0]      base_bytes;
	logic [RW-1:0]      cur_bytes;
	logic               cur_pl;
	logic               full_run;
	logic               report;
	logic [31:0]        found_nx;
	logic [15:0]        len16;
	logic [1:0]         nres;
	logic               deq;
	logic [1:0]         room;
	logic [1:0]         base_cnt;
	cpr_pkg::out_beat_t res [2];

	always_comb begin
		fresh      = rec.mismatch && !run_open_q;
		cur_open   = rec.mismatch || run_open_q;
		cur_start  = fresh ? rec.offset : run_start_q;
		base_bytes = fresh ? '0 : run_bytes_q;
		if (rec.mismatch) begin
			cur_bytes = base_bytes + 1'b1;
			cur_pl    = (!fresh && run_pl_q) || rec.opcode ||
				(!fresh && esc_q && rec.cond_tail);
		end else begin
			cur_bytes = run_bytes_q;
			cur_pl    = run_pl_q;
		end
		full_run = rec.mismatch && cur_bytes >= RW'(MAX_RUN);
		report   = cur_open && cur_pl && (!rec.mismatch || full_run || rec.last);
		found_nx = (report && found_q != '1) ? found_q + 1'b1 : found_q;
		len16    = 16'(cur_bytes);
		nres     = {1'b0, report} + {1'b0, rec.last};

		res[0].kind         = cpr_pkg::KIND_RUN;
		res[0].run_offset   = cur_start;
		res[0].run_length   = len16[6:0];
		res[0].run_count    = found_nx;
		res[0].end_of_burst = !rec.last;
		res[1].kind         = cpr_pkg::KIND_SUMMARY;
		res[1].run_offset   = '0;
		res[1].run_length   = '0;
		res[1].run_count    = found_nx;
		res[1].end_of_burst = 1'b1;
		if (!report) begin
			res[0] = res[1];
		end
	end

	assign out_valid = ocnt_q != '0;
	assign out_data  = obuf_q[0];
	assign deq       = out_valid && !out_stall;
	assign room      = (2'd2 - ocnt_q) + {1'b0, deq};
	assign pop       = !q_empty && room >= nres;

	always_comb begin
		base_cnt   = ocnt_q - {1'b0, deq};
		obuf_nx[0] = deq ? obuf_q[1] : obuf_q[0];
		obuf_nx[1] = obuf_q[1];
		ocnt_nx    = base_cnt;
		if (pop) begin
			ocnt_nx = base_cnt + nres;
			if (base_cnt == 2'd0) begin
				obuf_nx[0] = res[0];
				obuf_nx[1] = res[1];
			end else if (base_cnt == 2'd1) begin
				obuf_nx[1] = res[0];
			end
		end
	end

	always_ff @(posedge clk) begin
		obuf_q[0] <= obuf_nx[0];
		obuf_q[1] <= obuf_nx[1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ocnt_q      <= '0;
			run_open_q  <= 1'b0;
			run_start_q <= '0;
			run_bytes_q <= '0;
			run_pl_q    <= 1'b0;
			esc_q       <= 1'b0;
			found_q     <= '0;
		end else begin
			ocnt_q <= ocnt_nx;
			if (pop) begin
				if (rec.last) begin
					run_open_q  <= 1'b0;
					run_start_q <= '0;
					run_bytes_q <= '0;
					run_pl_q    <= 1'b0;
					esc_q       <= 1'b0;
					found_q     <= '0;
				end else begin
					run_start_q <= cur_start;
					found_q     <= found_nx;
					if (rec.mismatch && !full_run) begin
						run_open_q  <= 1'b1;
						run_bytes_q <= cur_bytes;
						run_pl_q    <= cur_pl;
						esc_q       <= rec.escape;
					end else begin
						run_open_q  <= 1'b0;
						run_bytes_q <= '0;
						run_pl_q    <= 1'b0;
						esc_q       <= 1'b0;
					end
				end
			end
		end
	end

`ifndef SYNTHESIS
	a_run_below_max: assert property (@(posedge clk) disable iff (!arst_n)
		run_bytes_q < RW'(MAX_RUN))
		else $error("open run reached its maximum length without closing");

	a_closed_run_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!run_open_q |-> run_bytes_q == '0 && !run_pl_q && !esc_q)
		else $error("closed run kept residual state");

	a_obuf_bound: assert property (@(posedge clk) disable iff (!arst_n)
		ocnt_q <= 2'd2)
		else $error("result buffer overfilled");

	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		pop && rec.last |=> !run_open_q && found_q == '0)
		else $error("region state not cleared after last beat");
`endif

endmodule

>>> design/code_patch_run_detector.sv
// Compares a stream of live code bytes against XOR-masked reference bytes, one beat per
// clock unless stalled, and reports each closed run of mismatching bytes that looks
// like a patch (offset, length and running count), plus a region summary on the beat
// marked last. The front end unmasks and classifies a byte in the cycle it is accepted
// and writes it to a four-entry queue; the back end updates the run state for one queued
// byte per cycle while its results fit, and places them in a two-entry output buffer.
// Sustained rate is one input beat per cycle while each beat yields at most one result
// and the output is not stalled; a beat that yields both a run report and a summary
// needs two output beats, so the output port sets the rate then. The user must write
// the key register only while the block is idle; the block itself does not enforce it.
module code_patch_run_detector #(
	parameter int MAX_RUN     = cpr_pkg::MAX_RUN_DEF,
	parameter int OFFSET_BITS = cpr_pkg::OFFSET_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               key_we,
	input  logic [63:0]        key_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  cpr_pkg::in_beat_t  in_data,
	output logic               out_valid,
	input  logic               out_stall,
	output cpr_pkg::out_beat_t out_data
);

	logic              push;
	logic              pop;
	logic              q_full;
	logic              q_empty;
	cpr_pkg::cls_rec_t push_rec;
	cpr_pkg::cls_rec_t head;

	cpr_front #(
		.OFFSET_BITS(OFFSET_BITS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.key_we   (key_we),
		.key_data (key_data),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_data  (in_data),
		.push     (push),
		.push_rec (push_rec),
		.q_full   (q_full)
	);

	cpr_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_rec (push_rec),
		.full     (q_full),
		.pop      (pop),
		.empty    (q_empty),
		.head     (head)
	);

	cpr_back #(
		.MAX_RUN(MAX_RUN)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (q_empty),
		.rec       (head),
		.pop       (pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

endmodule

>>> sim/testbench.sv
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int MAX_RUN = cpr_pkg::MAX_RUN_DEF;
	localparam logic [31:0] OFFSET_MAX = '1;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      key_we = 1'b0;
	logic [63:0] key_data = '0;
	logic      in_valid = 1'b0;
	logic      in_stall;
	cpr_pkg::in_beat_t  in_data = '0;
	logic      out_valid;
	logic      out_stall = 1'b0;
	cpr_pkg::out_beat_t out_data;

	cpr_pkg::in_beat_t  pending_bytes[$];
	cpr_pkg::out_beat_t expected_reports[$];
	cpr_pkg::out_beat_t burst[$];
	cpr_pkg::out_beat_t want;
	int        idle_pct = 16;
	int        errors = 0;
	int        stim_count = 0;
	logic [31:0] stim_offset = '0;

	logic [63:0] unmask_key = '0;
	logic [31:0] scan_offset = '0;
	logic        run_open = 1'b0;
	logic [31:0] run_start = '0;
	logic [6:0]  run_bytes = '0;
	logic        run_patchlike = 1'b0;
	logic        after_escape = 1'b0;
	logic [31:0] found_runs = '0;

	code_patch_run_detector u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.key_we   (key_we),
		.key_data (key_data),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data (out_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic jump_like(input logic [7:0] b);
		case (b)
			cpr_pkg::OP_JMP_REL, cpr_pkg::OP_CALL_REL, cpr_pkg::OP_JMP_SHRT,
			cpr_pkg::OP_RET, cpr_pkg::OP_RET_IMM, cpr_pkg::OP_INT3, cpr_pkg::OP_NOP,
			cpr_pkg::OP_GRP5: jump_like = 1'b1;
			default: jump_like = (b >= cpr_pkg::OP_JCC_LO) && (b <= cpr_pkg::OP_JCC_HI);
		endcase
	endfunction

	task automatic end_run();
		cpr_pkg::out_beat_t r;
		if (run_open && run_patchlike) begin
			if (found_runs != '1)
				found_runs++;
			r = '0;
			r.kind = cpr_pkg::KIND_RUN;
			r.run_offset = run_start;
			r.run_length = run_bytes;
			r.run_count = found_runs;
			burst = {burst, r};
		end
		run_open = 1'b0;
		run_bytes = '0;
		run_patchlike = 1'b0;
		after_escape = 1'b0;
	endtask

	task automatic scan_byte(input cpr_pkg::in_beat_t b);
		logic [7:0] clean;
		cpr_pkg::out_beat_t r;
		clean = b.stored_byte ^ unmask_key[scan_offset[2:0] * 8 +: 8];
		burst.delete();
		if (b.live_byte != clean) begin
			if (!run_open) begin
				run_open = 1'b1;
				run_start = scan_offset;
				run_bytes = '0;
				run_patchlike = 1'b0;
				after_escape = 1'b0;
			end
			run_bytes++;
			if (jump_like(b.live_byte) ||
				(after_escape && b.live_byte >= cpr_pkg::OP_JCC2_LO &&
				b.live_byte <= cpr_pkg::OP_JCC2_HI))
				run_patchlike = 1'b1;
			after_escape = (b.live_byte == cpr_pkg::OP_ESCAPE);
			if (run_bytes >= MAX_RUN)
				end_run();
		end else begin
			end_run();
		end
		if (scan_offset != OFFSET_MAX)
			scan_offset++;
		if (b.is_last) begin
			end_run();
			r = '0;
			r.kind = cpr_pkg::KIND_SUMMARY;
			r.run_count = found_runs;
			burst = {burst, r};
			scan_offset = '0;
			run_start = '0;
			found_runs = '0;
		end
		if (burst.size() != 0)
			burst[burst.size() - 1].end_of_burst = 1'b1;
		foreach (burst[i])
			expected_reports = {expected_reports, burst[i]};
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall)
				scan_byte(in_data);
			if (!in_valid || !in_stall) begin
				if (pending_bytes.size() != 0 && $urandom_range(99, 0) >= idle_pct) begin
					in_data <= pending_bytes.pop_front();
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (expected_reports.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("unexpected beat: kind %0d offset %0d length %0d count %0d eob %0d",
							out_data.kind, out_data.run_offset, out_data.run_length,
							out_data.run_count, out_data.end_of_burst);
				end else begin
					want = expected_reports.pop_front();
					if (out_data.kind !== want.kind || out_data.run_offset !== want.run_offset ||
						out_data.run_length !== want.run_length ||
						out_data.run_count !== want.run_count ||
						out_data.end_of_burst !== want.end_of_burst) begin
						errors++;
						if (errors <= 10) begin
							$display("mismatch: expected kind %0d offset %0d length %0d count %0d eob %0d",
								want.kind, want.run_offset, want.run_length, want.run_count,
								want.end_of_burst);
							$display("          got kind %0d offset %0d length %0d count %0d eob %0d",
								out_data.kind, out_data.run_offset, out_data.run_length,
								out_data.run_count, out_data.end_of_burst);
						end
					end
				end
			end
			out_stall <= (idle_pct != 0) && ($urandom_range(99, 0) < idle_pct);
		end
	end

	task automatic add_beat(input logic [7:0] live, input logic differ, input logic last);
		cpr_pkg::in_beat_t b;
		logic [7:0] flip;
		flip = differ ? 8'($urandom_range(255, 1)) : 8'h00;
		b.live_byte = live;
		b.stored_byte = live ^ unmask_key[stim_offset[2:0] * 8 +: 8] ^ flip;
		b.is_last = last;
		pending_bytes = {pending_bytes, b};
		stim_count++;
		stim_offset = last ? '0 : stim_offset + 1;
	endtask

	function automatic logic [7:0] run_byte();
		case ($urandom_range(9, 0))
			0: begin
				case ($urandom_range(7, 0))
					0: run_byte = cpr_pkg::OP_JMP_REL;
					1: run_byte = cpr_pkg::OP_CALL_REL;
					2: run_byte = cpr_pkg::OP_JMP_SHRT;
					3: run_byte = cpr_pkg::OP_RET;
					4: run_byte = cpr_pkg::OP_RET_IMM;
					5: run_byte = cpr_pkg::OP_INT3;
					6: run_byte = cpr_pkg::OP_NOP;
					default: run_byte = cpr_pkg::OP_GRP5;
				endcase
			end
			1: run_byte = 8'($urandom_range(cpr_pkg::OP_JCC_HI, cpr_pkg::OP_JCC_LO));
			2, 3: run_byte = cpr_pkg::OP_ESCAPE;
			4, 5: run_byte = 8'($urandom_range(cpr_pkg::OP_JCC2_HI, cpr_pkg::OP_JCC2_LO));
			default: run_byte = 8'($urandom);
		endcase
	endfunction

	task automatic add_region();
		int len;
		int run_left;
		int i;
		run_left = 0;
		if ($urandom_range(9, 0) == 0) begin
			len = $urandom_range(30, 10);
			for (i = 0; i < len; i++)
				add_beat(8'($urandom), 1'($urandom_range(1, 0)), $urandom_range(15, 0) == 0);
		end else begin
			len = ($urandom_range(7, 0) == 0) ? $urandom_range(90, 70) : $urandom_range(30, 2);
			for (i = 0; i < len; i++) begin
				if (run_left == 0 && $urandom_range(2, 0) == 0)
					run_left = ($urandom_range(9, 0) == 0) ? $urandom_range(70, 50) :
						$urandom_range(6, 1);
				if (run_left > 0) begin
					add_beat(run_byte(), 1'b1, i == len - 1);
					run_left--;
				end else begin
					add_beat(8'($urandom), 1'b0, i == len - 1);
				end
			end
		end
	endtask

	task automatic settle();
		do
			@(negedge clk);
		while (pending_bytes.size() != 0 || in_valid || expected_reports.size() != 0);
		repeat (12) @(posedge clk);
	endtask

	task automatic load_key(input logic [63:0] k);
		@(posedge clk);
		key_we <= 1'b1;
		key_data <= k;
		unmask_key = k;
		@(posedge clk);
		key_we <= 1'b0;
	endtask

	initial begin
		logic [63:0] phase_keys[5];
		int i;
		int target;
		phase_keys[0] = '0;
		phase_keys[1] = '1;
		phase_keys[2] = {$urandom, $urandom};
		phase_keys[3] = 64'h0123_4567_89AB_CDEF;
		phase_keys[4] = {$urandom, $urandom};

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		load_key(64'h0F1E_2D3C_4B5A_6978);

		add_beat(8'h00, 1'b0, 1'b0);
		add_beat(cpr_pkg::OP_JMP_REL, 1'b1, 1'b0);
		add_beat(cpr_pkg::OP_CALL_REL, 1'b1, 1'b0);
		add_beat(8'hFF, 1'b0, 1'b0);
		add_beat(cpr_pkg::OP_JMP_SHRT, 1'b1, 1'b0);
		add_beat(cpr_pkg::OP_RET, 1'b1, 1'b0);
		add_beat(8'h12, 1'b0, 1'b0);
		add_beat(cpr_pkg::OP_RET_IMM, 1'b1, 1'b0);
		add_beat(cpr_pkg::OP_INT3, 1'b1, 1'b0);
		add_beat(8'h34, 1'b0, 1'b0);
		add_beat(cpr_pkg::OP_NOP, 1'b1, 1'b0);
		add_beat(cpr_pkg::OP_GRP5, 1'b1, 1'b0);
		add_beat(8'h56, 1'b0, 1'b0);
		add_beat(cpr_pkg::OP_JCC_LO, 1'b1, 1'b0);
		add_beat(cpr_pkg::OP_JCC_HI, 1'b1, 1'b0);
		add_beat(8'h78, 1'b0, 1'b0);
		add_beat(8'h6F, 1'b1, 1'b0);
		add_beat(8'h80, 1'b1, 1'b0);
		add_beat(8'h55, 1'b0, 1'b0);
		add_beat(cpr_pkg::OP_ESCAPE, 1'b1, 1'b0);
		add_beat(cpr_pkg::OP_JCC2_LO, 1'b1, 1'b0);
		add_beat(8'h00, 1'b0, 1'b0);
		add_beat(cpr_pkg::OP_ESCAPE, 1'b1, 1'b0);
		add_beat(cpr_pkg::OP_JCC2_HI, 1'b1, 1'b0);
		add_beat(8'hAA, 1'b0, 1'b0);
		add_beat(cpr_pkg::OP_ESCAPE, 1'b1, 1'b0);
		add_beat(8'h00, 1'b0, 1'b0);
		add_beat(8'h85, 1'b1, 1'b0);
		add_beat(8'h00, 1'b0, 1'b0);
		for (i = 0; i < MAX_RUN - 1; i++)
			add_beat(8'h01, 1'b1, 1'b0);
		add_beat(cpr_pkg::OP_ESCAPE, 1'b1, 1'b0);
		add_beat(8'h80, 1'b1, 1'b0);
		add_beat(8'h00, 1'b0, 1'b0);
		add_beat(cpr_pkg::OP_CALL_REL, 1'b1, 1'b1);
		add_beat(8'h00, 1'b0, 1'b1);
		add_beat(8'hFF, 1'b1, 1'b0);
		add_beat(cpr_pkg::OP_ESCAPE, 1'b1, 1'b1);
		settle();

		for (int p = 0; p < 5; p++) begin
			load_key(phase_keys[p]);
			idle_pct = (p == 3) ? 0 : 16;
			target = stim_count + 120;
			while (stim_count < target)
				add_region();
			settle();
		end

		if (errors == 0 && expected_reports.size() == 0) begin
			$display("testbench OK");
		end else begin
			$display("testbench NOT OK");
		end
		$finish;
	end

	initial begin
		#2ms;
		$display("testbench NOT OK");
		$finish;
	end

endmodule

>>> filelist.f
design/cpr_pkg.sv
design/cpr_front.sv
design/cpr_queue.sv
design/cpr_back.sv
design/code_patch_run_detector.sv
sim/testbench.sv
